[src/pngf_pkg.sv]
// Shared types and constants of the PNG pixel filter codec.
package pngf_pkg;

    localparam int MAX_ROW_WIDTH = 1024;
    localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
    localparam int ROW_W         = 11;
    localparam int CNT_W         = (COL_W + 1 > ROW_W) ? COL_W + 1 : ROW_W;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 11;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION   = 2'd0,
        CFG_FILTER_KIND = 2'd1,
        CFG_ROW_WIDTH   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic       direction;
        logic [2:0] filter_kind;
        logic [10:0] row_width;
    } cfg_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic             sof;
        logic             first_row;
        logic             last;
        logic [COL_W-1:0] col;
        pixel_t           pix;
    } item_t;

endpackage

[src/pngf_front.sv]
// Front end: accept pixels, track column and row, classify each item.
module pngf_front
    import pngf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       push,
    input  logic       q_full,
    input  logic       start_of_frame,
    input  logic [7:0] in_red,
    input  logic [7:0] in_green,
    input  logic [7:0] in_blue,
    output logic       q_write,
    output item_t      q_item
);

    logic [COL_W-1:0] col_reg, col_next;
    logic             first_reg, first_next;
    logic [CNT_W-1:0] width_eff;
    logic [CNT_W-1:0] row_width_ext;
    logic [COL_W-1:0] x;
    logic             first_row;
    logic             last;

    assign row_width_ext = CNT_W'(cfg.row_width);

    always_comb
    begin
        if (row_width_ext == '0)
            width_eff = CNT_W'(1);
        else if (row_width_ext > CNT_W'(MAX_ROW_WIDTH))
            width_eff = CNT_W'(MAX_ROW_WIDTH);
        else
            width_eff = row_width_ext;
    end

    // Start of frame restarts the position before this pixel is placed
    assign x         = start_of_frame ? '0 : col_reg;
    assign first_row = start_of_frame ? 1'b1 : first_reg;
    assign last      = (CNT_W'(x) + CNT_W'(1)) >= width_eff;

    assign q_write = push && !q_full;

    always_comb
    begin
        q_item.sof       = start_of_frame;
        q_item.first_row = first_row;
        q_item.last      = last;
        q_item.col       = x;
        q_item.pix.red   = in_red;
        q_item.pix.green = in_green;
        q_item.pix.blue  = in_blue;
    end

    always_comb
    begin
        col_next   = col_reg;
        first_next = first_reg;
        if (q_write)
        begin
            if (last)
            begin
                col_next   = '0;
                first_next = 1'b0;
            end
            else
            begin
                col_next   = x + COL_W'(1);
                first_next = first_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            col_reg   <= col_next;
            first_reg <= first_next;
        end
    end

endmodule

[src/pngf_queue.sv]
// Two-entry queue of classified items between front and back ends.
module pngf_queue
    import pngf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr,
    input  item_t wr_item,
    input  logic  rd,
    output logic  full,
    output logic  not_empty,
    output item_t rd_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full      = count_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign rd_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(wr) - (PTR_W+1)'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

[src/pngf_back.sv]
// Back end: line store read, predictor, encode or decode, result register.
module pngf_back
    import pngf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_not_empty,
    input  item_t      q_item,
    output logic       q_read,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic       end_of_row
);

    function automatic logic [7:0] predict(logic [2:0] kind, logic [7:0] a,
                                           logic [7:0] b, logic [7:0] c);
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dsum;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        logic [8:0]        sum;
        logic [7:0]        res;
        da   = $signed({2'b00, a}) - $signed({2'b00, c});
        db   = $signed({2'b00, b}) - $signed({2'b00, c});
        dsum = da + db;
        pa   = db[9] ? 10'(-db) : 10'(db);
        pb   = da[9] ? 10'(-da) : 10'(da);
        pc   = dsum[9] ? 10'(-dsum) : 10'(dsum);
        sum  = {1'b0, a} + {1'b0, b};
        case (kind)
            FILT_SUB:   res = a;
            FILT_UP:    res = b;
            FILT_AVG:   res = sum[8:1];
            FILT_PAETH:
            begin
                if (pa <= pb && pa <= pc)
                    res = a;
                else if (pb <= pc)
                    res = b;
                else
                    res = c;
            end
            default:    res = 8'd0;
        endcase
        return res;
    endfunction

    logic   [23:0] line_mem [MAX_ROW_WIDTH];
    logic          a_valid_reg, a_valid_next;
    item_t         a_item_reg;
    pixel_t        upper_rd_reg;
    pixel_t        left_reg, left_next;
    pixel_t        ul_reg, ul_next;
    logic          out_valid_reg, out_valid_next;
    pixel_t        out_pix_reg;
    logic          out_last_reg;

    logic          fire;
    pixel_t        left_px, ul_px, upper_px;
    pixel_t        pred_px, res_px, raw_px;

    assign fire   = a_valid_reg && (!out_valid_reg || pop);
    assign q_read = q_not_empty && (!a_valid_reg || fire);

    // Neighbours outside the frame count as zero
    assign left_px  = a_item_reg.sof ? '0 : left_reg;
    assign ul_px    = a_item_reg.sof ? '0 : ul_reg;
    assign upper_px = a_item_reg.first_row ? '0 : upper_rd_reg;

    always_comb
    begin
        pred_px.red   = predict(cfg.filter_kind, left_px.red, upper_px.red, ul_px.red);
        pred_px.green = predict(cfg.filter_kind, left_px.green, upper_px.green,
                                ul_px.green);
        pred_px.blue  = predict(cfg.filter_kind, left_px.blue, upper_px.blue,
                                ul_px.blue);
        if (cfg.direction)
        begin
            res_px.red   = a_item_reg.pix.red + pred_px.red;
            res_px.green = a_item_reg.pix.green + pred_px.green;
            res_px.blue  = a_item_reg.pix.blue + pred_px.blue;
            raw_px       = res_px;
        end
        else
        begin
            res_px.red   = a_item_reg.pix.red - pred_px.red;
            res_px.green = a_item_reg.pix.green - pred_px.green;
            res_px.blue  = a_item_reg.pix.blue - pred_px.blue;
            raw_px       = a_item_reg.pix;
        end
    end

    always_comb
    begin
        a_valid_next   = a_valid_reg;
        left_next      = left_reg;
        ul_next        = ul_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
            out_valid_next = 1'b0;
        if (fire)
        begin
            out_valid_next = 1'b1;
            a_valid_next   = 1'b0;
            left_next      = a_item_reg.last ? '0 : raw_px;
            ul_next        = a_item_reg.last ? '0 : upper_px;
        end
        if (q_read)
            a_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            ul_reg        <= '0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
            left_reg      <= left_next;
            ul_reg        <= ul_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_read)
            a_item_reg <= q_item;
        if (fire)
        begin
            out_pix_reg  <= res_px;
            out_last_reg <= a_item_reg.last;
        end
    end

    // Line store: write the finished pixel, read ahead for the next item;
    // forward the write when both hit the same column
    always_ff @(posedge clk)
    begin
        if (fire)
            line_mem[a_item_reg.col] <= raw_px;
        if (q_read)
        begin
            if (fire && a_item_reg.col == q_item.col)
                upper_rd_reg <= raw_px;
            else
                upper_rd_reg <= line_mem[q_item.col];
        end
    end

    assign empty      = !out_valid_reg;
    assign out_red    = out_pix_reg.red;
    assign out_green  = out_pix_reg.green;
    assign out_blue   = out_pix_reg.blue;
    assign end_of_row = out_last_reg;

endmodule

[src/png_pixel_filter_codec_top.sv]
// Top level of the PNG pixel filter codec: configuration registers and wiring.
//
//  Channel   Handshake          Payload
//  --------  -----------------  ----------------------------------------------
//  input     push / full        start_of_frame, in_red, in_green, in_blue
//  result    empty / pop        out_red, out_green, out_blue, end_of_row
//  config    cfg_write          cfg_index, cfg_data (no wait, no read-back)
//
// One item per clock sustained while neither side stalls; a result passes
// through the queue write, then line store read, then result register on its
// way to the ports. The loop through the left pixel, predictor and adder
// sets the rate.
// Reset clears control state and configuration; the line store is not
// cleared, as the first row of each frame never reads it.
// Either side may stall alone: the two-entry queue and the result register
// absorb back-pressure, and full rises only when both queue entries are
// occupied.
module png_pixel_filter_codec_top
    import pngf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  start_of_frame,
    input  logic [7:0]            in_red,
    input  logic [7:0]            in_green,
    input  logic [7:0]            in_blue,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            out_red,
    output logic [7:0]            out_green,
    output logic [7:0]            out_blue,
    output logic                  end_of_row,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    logic  q_write;
    logic  q_read;
    logic  q_not_empty;
    item_t q_wr_item;
    item_t q_rd_item;

    // Decode register writes; unused indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DIRECTION:   cfg_next.direction   = cfg_data[0];
                CFG_FILTER_KIND: cfg_next.filter_kind = cfg_data[2:0];
                CFG_ROW_WIDTH:   cfg_next.row_width   = cfg_data[10:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction   <= 1'b0;
            cfg_reg.filter_kind <= FILT_NONE;
            cfg_reg.row_width   <= 11'd1024;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: take pixels and work out where they sit in the frame
    pngf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .push           (push),
        .q_full         (full),
        .start_of_frame (start_of_frame),
        .in_red         (in_red),
        .in_green       (in_green),
        .in_blue        (in_blue),
        .q_write        (q_write),
        .q_item         (q_wr_item)
    );

    // Decouple the two halves
    pngf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_write),
        .wr_item   (q_wr_item),
        .rd        (q_read),
        .full      (full),
        .not_empty (q_not_empty),
        .rd_item   (q_rd_item)
    );

    // Back end: predict, filter or reconstruct, hold the result
    pngf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_item      (q_rd_item),
        .q_read      (q_read),
        .pop         (pop),
        .empty       (empty),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .end_of_row  (end_of_row)
    );

endmodule

[verif/png_pixel_filter_codec_tb.sv]
// Self-checking testbench for the PNG pixel filter codec: directed table, then random frames.
module tb
    import pngf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Register data that the package leaves unnamed.
    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE      = 2'd3;
    localparam logic [CFG_DATA_W-1:0] DIR_ENCODE     = 11'd0;
    localparam logic [CFG_DATA_W-1:0] DIR_DECODE     = 11'd1;
    localparam logic [2:0]            FILT_UNUSED_LO = 3'd5;
    localparam logic [2:0]            FILT_UNUSED_MD = 3'd6;
    localparam logic [2:0]            FILT_UNUSED_HI = 3'd7;

    localparam int RANDOM_ITEMS = 350;
    localparam int WIDE_ROW     = 48;
    localparam int STUCK_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 8;
    localparam int SHOWN_ERRORS = 10;

    // One coded pixel as it leaves the block.
    typedef struct packed {
        pixel_t pix;
        logic   row_end;
    } coded_px_t;

    // One row of the directed table: a register write or an input item,
    // the latter optionally with its result written out by hand.
    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  sof;
        pixel_t                px;
        logic                  known;
        coded_px_t             known_res;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  start_of_frame = 1'b0;
    logic [7:0]            in_red = 8'h00;
    logic [7:0]            in_green = 8'h00;
    logic [7:0]            in_blue = 8'h00;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    logic                  end_of_row;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the codec: configuration, neighbour pixels, position and line store.
    logic                  decode_mode = 1'b0;
    logic [2:0]            filter_sel = FILT_NONE;
    logic [CFG_DATA_W-1:0] row_width_reg = 11'd1024;
    pixel_t                left_px = '0;
    pixel_t                upleft_px = '0;
    int unsigned           col_pos = 0;
    logic                  on_first_row = 1'b1;
    pixel_t                line_mem [MAX_ROW_WIDTH];
    bit                    line_written [MAX_ROW_WIDTH];

    coded_px_t   pixels_due [$];
    stim_row_t   directed_rows [$];
    int unsigned items_sent = 0;
    int unsigned frames_started = 0;
    int unsigned results_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatches = 0;
    int unsigned pop_hold = 0;
    int unsigned stuck_cycles = 0;
    int unsigned quiet_left = 0;
    logic        quiet = 1'b0;

    png_pixel_filter_codec_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .start_of_frame (start_of_frame),
        .in_red         (in_red),
        .in_green       (in_green),
        .in_blue        (in_blue),
        .empty          (empty),
        .pop            (pop),
        .out_red        (out_red),
        .out_green      (out_green),
        .out_blue       (out_blue),
        .end_of_row     (end_of_row),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Predictor of one channel from left (a), upper (b) and upper-left (c).
    function automatic logic [7:0] filter_pred(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
        int         ia, ib, ic, est, da, db, dc;
        logic [8:0] sum;
        ia  = a;
        ib  = b;
        ic  = c;
        sum = a + b;
        est = ia + ib - ic;
        da  = (est > ia) ? est - ia : ia - est;
        db  = (est > ib) ? est - ib : ib - est;
        dc  = (est > ic) ? est - ic : ic - est;
        case (filter_sel)
            FILT_SUB:   return a;
            FILT_UP:    return b;
            FILT_AVG:   return sum[8:1];
            // Nearest of the three wins; ties go to left, then to upper.
            FILT_PAETH: return (da <= db && da <= dc) ? a : ((db <= dc) ? b : c);
            default:    return 8'h00;
        endcase
    endfunction

    // Advance the shadow by one input item and return the coded pixel it yields.
    function automatic coded_px_t code_pixel(input logic sof, input pixel_t in_px);
        coded_px_t   res;
        pixel_t      upper, raw;
        int unsigned w, x, k;
        logic [7:0]  v, p, o;
        w = (row_width_reg == 0) ? 1 :
            ((row_width_reg > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : row_width_reg);
        if (sof)
        begin
            col_pos      = 0;
            on_first_row = 1'b1;
            left_px      = '0;
            upleft_px    = '0;
        end
        x     = (col_pos >= MAX_ROW_WIDTH) ? MAX_ROW_WIDTH - 1 : col_pos;
        upper = on_first_row ? '0 : line_mem[x];
        for (k = 0; k < 3; k++)
        begin
            v = in_px[8*k +: 8];
            p = filter_pred(left_px[8*k +: 8], upper[8*k +: 8], upleft_px[8*k +: 8]);
            o = decode_mode ? v + p : v - p;
            res.pix[8*k +: 8] = o;
            raw[8*k +: 8]     = decode_mode ? o : v;
        end
        line_mem[x]     = raw;
        line_written[x] = 1'b1;
        upleft_px       = upper;
        left_px         = raw;
        res.row_end     = (x + 1 >= w);
        if (res.row_end)
        begin
            col_pos      = 0;
            on_first_row = 1'b0;
            left_px      = '0;
            upleft_px    = '0;
        end
        else
            col_pos = x + 1;
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long, none in quiet stretches.
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return $urandom_range(0, 1) ? 8'h80 : 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row         = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic stim_row_t px_row(input logic sof, input logic [7:0] r,
                                         input logic [7:0] g, input logic [7:0] b);
        stim_row_t row;
        row           = '0;
        row.sof       = sof;
        row.px.red    = r;
        row.px.green  = g;
        row.px.blue   = b;
        return row;
    endfunction

    function automatic stim_row_t known_row(input logic sof, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic [7:0] er, input logic [7:0] eg,
                                            input logic [7:0] eb, input logic last);
        stim_row_t row;
        row                     = px_row(sof, r, g, b);
        row.known               = 1'b1;
        row.known_res.pix.red   = er;
        row.known_res.pix.green = eg;
        row.known_res.pix.blue  = eb;
        row.known_res.row_end   = last;
        return row;
    endfunction

    // Drop push and hold until every coded pixel owed has come out.
    task automatic drain_results();
        push <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
    endtask

    // Write one register with the block idle; the shadow follows at the same edge.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        drain_results();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_DIRECTION:   decode_mode   = val[0];
            CFG_FILTER_KIND: filter_sel    = val[2:0];
            CFG_ROW_WIDTH:   row_width_reg = val;
            default:         ;
        endcase
        reg_writes++;
    endtask

    // Offer one item, hold it until it is taken, then queue its coded pixel.
    task automatic send_pixel(input logic sof, input pixel_t px, input logic known,
                              input coded_px_t known_res);
        int unsigned gap;
        coded_px_t   res;
        gap = idle_gap();
        cfg_write <= 1'b0;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // A row after the first must never read a line store entry never written:
        // start a fresh frame instead.
        if (!on_first_row && !line_written[col_pos])
            sof = 1'b1;
        push           <= 1'b1;
        start_of_frame <= sof;
        in_red         <= px.red;
        in_green       <= px.green;
        in_blue        <= px.blue;
        do
            @(posedge clk);
        while (full);
        res = code_pixel(sof, px);
        pixels_due.push_back(known ? known_res : res);
        items_sent++;
        if (sof)
            frames_started++;
    endtask

    // Alternate quiet stretches, with no idling on either side, and busy ones.
    always @(posedge clk)
    begin
        if (quiet_left == 0)
        begin
            quiet_left = $urandom_range(40, 300);
            quiet <= ($urandom_range(0, 3) == 0);
        end
        else
            quiet_left--;
    end

    // Result side: check each popped pixel against the oldest one owed, and
    // stall pop at random.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (pixels_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("%0t: unexpected pixel %02h %02h %02h row end %0b", $realtime,
                             out_red, out_green, out_blue, end_of_row);
            end
            else if (out_red !== pixels_due[0].pix.red
                     || out_green !== pixels_due[0].pix.green
                     || out_blue !== pixels_due[0].pix.blue
                     || end_of_row !== pixels_due[0].row_end)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("%0t: pixel %0d exp %02h %02h %02h/%0b got %02h %02h %02h/%0b",
                             $realtime, results_seen, pixels_due[0].pix.red,
                             pixels_due[0].pix.green, pixels_due[0].pix.blue,
                             pixels_due[0].row_end, out_red, out_green, out_blue, end_of_row);
                void'(pixels_due.pop_front());
            end
            else
                void'(pixels_due.pop_front());
        end
        if (pop_hold != 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else
        begin
            pop <= 1'b1;
            pop_hold = idle_gap();
        end
    end

    // Watchdog: end the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_write)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Watchdog: nothing moved for %0d cycles, %0d pixels still owed",
                     STUCK_LIMIT, pixels_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase_len, n, r;
        logic        sof;
        logic [2:0]  kind;
        logic [10:0] width;
        pixel_t      px;

        // Directed part. After reset the codec encodes with no filter at width
        // 1024, so the opening items come out unchanged.
        directed_rows = '{
            // no start of frame after reset: acts as a frame start
            known_row(1'b0, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h00, 8'h80, 1'b0),
            known_row(1'b1, 8'h00, 8'hFF, 8'h7F, 8'h00, 8'hFF, 8'h7F, 1'b0),
            known_row(1'b0, 8'h01, 8'h80, 8'hFE, 8'h01, 8'h80, 8'hFE, 1'b0),
            // width lowered below the current column: this item ends the row
            reg_row(CFG_ROW_WIDTH, 11'd1),
            known_row(1'b0, 8'hAA, 8'h55, 8'h01, 8'hAA, 8'h55, 8'h01, 1'b1),
            // sub at width zero (acts as one): left is always zero
            reg_row(CFG_FILTER_KIND, CFG_DATA_W'(FILT_SUB)),
            reg_row(CFG_ROW_WIDTH, 11'd0),
            known_row(1'b1, 8'h10, 8'h20, 8'h30, 8'h10, 8'h20, 8'h30, 1'b1),
            known_row(1'b0, 8'h11, 8'h22, 8'h33, 8'h11, 8'h22, 8'h33, 1'b1),
            // up: subtract the pixel above, wrapping below zero
            reg_row(CFG_FILTER_KIND, CFG_DATA_W'(FILT_UP)),
            known_row(1'b0, 8'h05, 8'h25, 8'h35, 8'hF4, 8'h03, 8'h02, 1'b1),
            // up in decode: add the pixel above, wrapping past 255
            reg_row(CFG_DIRECTION, DIR_DECODE),
            known_row(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h04, 8'h24, 8'h34, 1'b1),
            // an index with no register behind it changes nothing
            reg_row(CFG_SPARE, 11'h7FF),
            // average, width raised mid-frame over columns already stored
            reg_row(CFG_ROW_WIDTH, 11'd3),
            reg_row(CFG_FILTER_KIND, CFG_DATA_W'(FILT_AVG)),
            px_row(1'b0, 8'hFF, 8'hFF, 8'hFF),
            px_row(1'b0, 8'h00, 8'h00, 8'h00),
            px_row(1'b0, 8'h80, 8'h7F, 8'h01),
            px_row(1'b0, 8'hFE, 8'h01, 8'h80),
            px_row(1'b0, 8'h7F, 8'h80, 8'hFF),
            px_row(1'b0, 8'h01, 8'hFE, 8'h00),
            // paeth with flat areas to force ties
            reg_row(CFG_FILTER_KIND, CFG_DATA_W'(FILT_PAETH)),
            px_row(1'b0, 8'h40, 8'h40, 8'h40),
            px_row(1'b0, 8'h40, 8'h40, 8'h40),
            px_row(1'b0, 8'h40, 8'h40, 8'h40),
            px_row(1'b0, 8'h40, 8'h40, 8'h40),
            px_row(1'b0, 8'h00, 8'h00, 8'h00),
            px_row(1'b0, 8'hC0, 8'h20, 8'hA0),
            // unknown kinds act as none; encode passes items through
            reg_row(CFG_FILTER_KIND, CFG_DATA_W'(FILT_UNUSED_HI)),
            reg_row(CFG_DIRECTION, DIR_ENCODE),
            known_row(1'b0, 8'h12, 8'h34, 8'h56, 8'h12, 8'h34, 8'h56, 1'b0),
            reg_row(CFG_FILTER_KIND, CFG_DATA_W'(FILT_UNUSED_LO)),
            known_row(1'b0, 8'h9A, 8'hBC, 8'hDE, 8'h9A, 8'hBC, 8'hDE, 1'b0),
            // width past the maximum acts as the maximum
            reg_row(CFG_FILTER_KIND, CFG_DATA_W'(FILT_UNUSED_MD)),
            reg_row(CFG_ROW_WIDTH, 11'h7FF),
            known_row(1'b0, 8'hFE, 8'hDC, 8'hBA, 8'hFE, 8'hDC, 8'hBA, 1'b0)
        };

        // Hold reset, then release it once for good.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_reg)
                write_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            else
                send_pixel(directed_rows[i].sof, directed_rows[i].px,
                           directed_rows[i].known, directed_rows[i].known_res);
        end

        // One frame of two wide rows and a little more, decoded through paeth,
        // so that the second row reads every column the first one stored.
        write_register(CFG_ROW_WIDTH, CFG_DATA_W'(WIDE_ROW));
        write_register(CFG_FILTER_KIND, CFG_DATA_W'(FILT_PAETH));
        write_register(CFG_DIRECTION, DIR_DECODE);
        for (n = 0; n < 2 * WIDE_ROW + 8; n++)
        begin
            px = '{blue: rand_chan(), green: rand_chan(), red: rand_chan()};
            send_pixel(n == 0, px, 1'b0, '0);
        end

        // Random part: phases of frames at mostly narrow widths, each phase
        // opened by a reconfiguration while the block is idle.
        n = items_sent;
        while (items_sent < n + RANDOM_ITEMS)
        begin
            // Only bit 0 of the direction counts; the rest is noise.
            if ($urandom_range(0, 2) != 0)
                write_register(CFG_DIRECTION, 11'($urandom));
            if ($urandom_range(0, 2) != 0)
            begin
                kind = ($urandom_range(0, 9) == 0)
                       ? 3'($urandom_range(FILT_UNUSED_LO, FILT_UNUSED_HI))
                       : 3'($urandom_range(FILT_NONE, FILT_PAETH));
                write_register(CFG_FILTER_KIND, {8'($urandom), kind});
            end
            if ($urandom_range(0, 2) != 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    width = 11'($urandom_range(1, 8));
                else if (r < 92)
                    width = 11'($urandom_range(9, 64));
                else if (r < 96)
                    width = 11'd0;
                else
                    width = 11'($urandom_range(MAX_ROW_WIDTH + 1, 2047));
                write_register(CFG_ROW_WIDTH, width);
            end
            phase_len = $urandom_range(4, 60);
            for (int unsigned j = 0; j < phase_len; j++)
            begin
                // Open about half the phases with a new frame, and now and
                // then restart one in the middle.
                sof = (j == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 49) == 0);
                px  = '{blue: rand_chan(), green: rand_chan(), red: rand_chan()};
                send_pixel(sof, px, 1'b0, '0);
                // Sometimes hold the sender until the block has emptied.
                if ($urandom_range(0, 99) == 0)
                    drain_results();
            end
        end

        // Wait for the last coded pixels, then idle a while longer for strays.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d items in %0d frames and %0d register writes;",
                 items_sent, frames_started, reg_writes);
        $display("all filter kinds both ways, widths from zero past the maximum, %0d results.",
                 results_seen);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
